[hw/rtl/analog_register_bus_host_defines.svh]
// ----------------------------------------------------------------------------
// Analog register bus host: assertion macros
// Shared property wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ANALOG_REGISTER_BUS_HOST_DEFINES_SVH
`define ANALOG_REGISTER_BUS_HOST_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define ABH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled in reset
`define ABH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ABH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ABH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/abh_pkg.sv]
// ----------------------------------------------------------------------------
// abh_pkg
// Constants, codes and types shared by the analog register bus host.
// ----------------------------------------------------------------------------
package abh_pkg;

    localparam int HOSTS      = 2;
    localparam int SLAVE_BITS = 8;
    localparam int ADDR_BITS  = 8;

    localparam int STORE_AW = SLAVE_BITS + ADDR_BITS;
    localparam int HOST_W   = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int CMD_W    = 27;

    // command word layout
    localparam int CMD_ADDR_LSB = 8;
    localparam int CMD_DATA_LSB = 16;
    localparam int CMD_WRITE    = 24;
    localparam int CMD_START    = 25;
    localparam int CMD_BUSY     = 26;

    localparam logic [31:0] CMD_KNOWN = 32'h03FF_0000
        | ((32'd1 << SLAVE_BITS) - 32'd1)
        | (((32'd1 << ADDR_BITS) - 32'd1) << CMD_ADDR_LSB);

    // analog control word bits
    localparam int STOP_LOW  = 0;
    localparam int STOP_HIGH = 1;
    localparam int PLL_DONE  = 2;

    localparam logic [1:0] DONE_READS = 2'd2;
    localparam logic [1:0] CNT_MAX    = 2'd3;

    // word map
    localparam logic [3:0] W_ANALOG = 4'(HOSTS);
    localparam logic [3:0] W_CFG    = 4'(HOSTS + 1);
    localparam logic [3:0] W_CFG2   = 4'(HOSTS + 2);

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [2:0] {
        CFG_ANA_MASK  = 3'd0,
        CFG_ANA_RST   = 3'd1,
        CFG_CFG_MASK  = 3'd2,
        CFG_CFG2_MASK = 3'd3,
        CFG_SAR_ID    = 3'd4,
        CFG_SAR_EN    = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_store_req;

endpackage

[hw/rtl/abh_byte_store.sv]
// ----------------------------------------------------------------------------
// abh_byte_store
// Single-port analog byte store with a clearing pass after reset.
// ----------------------------------------------------------------------------
module abh_byte_store import abh_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output logic [7:0] o_rdata,
    output logic       o_ready
);

    logic [7:0]          r_mem [2**STORE_AW];
    logic [7:0]          r_rdata;
    logic [STORE_AW-1:0] r_clr_addr;
    logic                r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_req.en && i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en && !i_req.we) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule

[hw/rtl/analog_register_bus_host.sv]
// A result is registered at the edge that takes the item.
// Throughput: one item per cycle while the result output is not stalled, except that a
// started command read of the byte store holds off items until the byte is back (ST_READ).
// Reset: synchronous, active low; clears the state and configuration registers but not the
// pending command or result data; a clearing pass then zeroes all 2**(SLAVE_BITS+ADDR_BITS) =
// 65536 store bytes; no item is taken meanwhile, configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// analog_register_bus_host
// Register-mapped host: command words driving the analog byte store, analog control
// with PLL calibration, two masked configuration words, and an APB configuration port.
// ----------------------------------------------------------------------------
`include "analog_register_bus_host_defines.svh"

module analog_register_bus_host import abh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [3:0]  i_word_index,
    input  logic [31:0] i_write_value,
    input  logic        i_sar_powered,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_rd_word,
    output logic        o_mapped,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [31:0] r_ana_mask, r_ana_rst, r_cfg_mask, r_cfg2_mask;
    logic [7:0]  r_sar_id;
    logic        r_sar_en;

    // block state
    logic [CMD_W-1:0] r_cmd [HOSTS];
    logic [CMD_W-1:0] n_cmd [HOSTS];
    logic [31:0]      r_ana, n_ana;
    logic [31:0]      r_cfg, n_cfg;
    logic [31:0]      r_cfg2, n_cfg2;
    logic [1:0]       r_cnt, n_cnt;
    logic             r_calib, n_calib;
    logic             r_done, n_done;
    t_state           r_state, n_state;
    logic [HOST_W-1:0] r_pend_host, n_pend_host;
    logic [CMD_W-1:0]  r_pend_cmd, n_pend_cmd;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic        r_out_mapped, n_out_mapped;

    t_store_req  store_req;
    logic [7:0]  store_rdata;
    logic        store_ready;

    logic        apb_wr;
    t_cfg_idx    cfg_idx;
    logic        out_free;
    logic        in_ready;
    logic        in_acc;
    logic [31:0] cmd_in;
    logic [HOST_W-1:0] host;
    logic        sar_hit;
    logic [31:0] ana_now;

    abh_byte_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rdata (store_rdata),
        .o_ready (store_ready)
    );

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_cfg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ana_mask  <= 32'd3;
            r_ana_rst   <= 32'd0;
            r_cfg_mask  <= '1;
            r_cfg2_mask <= '1;
            r_sar_id    <= 8'd0;
            r_sar_en    <= 1'b0;
        end else if (apb_wr) begin
            unique case (cfg_idx)
                CFG_ANA_MASK:  r_ana_mask  <= pwdata;
                CFG_ANA_RST:   r_ana_rst   <= pwdata;
                CFG_CFG_MASK:  r_cfg_mask  <= pwdata;
                CFG_CFG2_MASK: r_cfg2_mask <= pwdata;
                CFG_SAR_ID:    r_sar_id    <= pwdata[7:0];
                CFG_SAR_EN:    r_sar_en    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_ANA_MASK:  prdata = r_ana_mask;
            CFG_ANA_RST:   prdata = r_ana_rst;
            CFG_CFG_MASK:  prdata = r_cfg_mask;
            CFG_CFG2_MASK: prdata = r_cfg2_mask;
            CFG_SAR_ID:    prdata = {24'd0, r_sar_id};
            CFG_SAR_EN:    prdata = {31'd0, r_sar_en};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // item handshake
    // ------------------------------------------------------------------
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_ready   = (r_state == ST_IDLE) && store_ready && out_free;
    assign in_acc     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    assign cmd_in  = i_write_value & CMD_KNOWN;
    assign host    = i_word_index[HOST_W-1:0];
    assign sar_hit = r_sar_en && !i_sar_powered
                     && (8'(cmd_in[SLAVE_BITS-1:0]) == r_sar_id);
    assign ana_now = i_write_value & r_ana_mask & ~(32'd1 << PLL_DONE);

    always_comb begin
        n_cmd        = r_cmd;
        n_ana        = r_ana;
        n_cfg        = r_cfg;
        n_cfg2       = r_cfg2;
        n_cnt        = r_cnt;
        n_calib      = r_calib;
        n_done       = r_done;
        n_state      = r_state;
        n_pend_host  = r_pend_host;
        n_pend_cmd   = r_pend_cmd;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        n_out_mapped = r_out_mapped;
        store_req    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = 32'd0;
                    n_out_mapped = 1'b1;
                    if (i_word_index < W_ANALOG) begin
                        if (i_action == ACT_WRITE) begin
                            n_cmd[host] = cmd_in[CMD_W-1:0];
                            if (cmd_in[CMD_START]) begin
                                if (sar_hit) begin
                                    n_cmd[host][CMD_BUSY] = 1'b1;
                                end else begin
                                    store_req.en   = 1'b1;
                                    store_req.addr = {cmd_in[SLAVE_BITS-1:0],
                                                      cmd_in[CMD_ADDR_LSB +: ADDR_BITS]};
                                    if (cmd_in[CMD_WRITE]) begin
                                        store_req.we    = 1'b1;
                                        store_req.wdata = cmd_in[CMD_DATA_LSB +: 8];
                                    end else begin
                                        // fill the data field once the byte is back
                                        n_state     = ST_READ;
                                        n_pend_host = host;
                                        n_pend_cmd  = cmd_in[CMD_W-1:0];
                                    end
                                end
                            end
                        end else begin
                            n_out_data = {{(32-CMD_W){1'b0}}, r_cmd[host]};
                        end
                    end else if (i_word_index == W_ANALOG) begin
                        if (i_action == ACT_WRITE) begin
                            n_ana = ana_now;
                            if (ana_now[STOP_LOW] && !ana_now[STOP_HIGH]
                                && !r_ana[STOP_LOW]) begin
                                n_cnt   = 2'd0;
                                n_calib = 1'b1;
                                n_done  = 1'b0;
                            end else if (ana_now[STOP_HIGH]) begin
                                n_calib = 1'b0;
                                n_done  = 1'b0;
                            end
                        end else begin
                            if (r_calib) begin
                                if (r_cnt < CNT_MAX) begin
                                    n_cnt = r_cnt + 2'd1;
                                end
                                if (n_cnt >= DONE_READS) begin
                                    n_calib = 1'b0;
                                    n_done  = 1'b1;
                                end
                            end
                            n_out_data = r_ana | ({31'd0, n_done} << PLL_DONE);
                        end
                    end else if (i_word_index == W_CFG) begin
                        if (i_action == ACT_WRITE) begin
                            n_cfg = i_write_value & r_cfg_mask;
                        end else begin
                            n_out_data = r_cfg;
                        end
                    end else if (i_word_index == W_CFG2) begin
                        if (i_action == ACT_WRITE) begin
                            n_cfg2 = i_write_value & r_cfg2_mask;
                        end else begin
                            n_out_data = r_cfg2;
                        end
                    end else begin
                        n_out_mapped = 1'b0;
                    end
                end
            end
            ST_READ: begin
                n_cmd[r_pend_host] = {r_pend_cmd[CMD_W-1:CMD_DATA_LSB+8], store_rdata,
                                      r_pend_cmd[CMD_DATA_LSB-1:0]};
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int h = 0; h < HOSTS; h++) begin
                r_cmd[h] <= '0;
            end
            r_ana       <= 32'd0;
            r_cfg       <= 32'd0;
            r_cfg2      <= 32'd0;
            r_cnt       <= 2'd0;
            r_calib     <= 1'b0;
            r_done      <= 1'b0;
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd       <= n_cmd;
            r_ana       <= n_ana;
            r_cfg       <= n_cfg;
            r_cfg2      <= n_cfg2;
            r_cnt       <= n_cnt;
            r_calib     <= n_calib;
            r_done      <= n_done;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_host  <= n_pend_host;
        r_pend_cmd   <= n_pend_cmd;
        r_out_data   <= n_out_data;
        r_out_mapped <= n_out_mapped;
    end

    assign o_out_valid = r_out_valid;
    assign o_rd_word   = r_out_data;
    assign o_mapped    = r_out_mapped;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `ABH_ASSERT_SAME(a_read_follows_accept, i_clk, i_rst_n, r_state == ST_READ, $past(in_acc), "store read state without a preceding transfer")
    `ABH_ASSERT_SAME(a_out_from_accept, i_clk, i_rst_n, $rose(r_out_valid), $past(in_acc), "result appeared without an accepted transfer")
    `ABH_ASSERT_SAME(a_no_store_in_read, i_clk, i_rst_n, r_state == ST_READ, !store_req.en, "store accessed while a command read is pending")
    `ABH_ASSERT_NEXT(a_clear_blocks_items, i_clk, i_rst_n, !store_ready, !$past(in_acc), "transfer taken during the clearing pass")

endmodule

[test/tb_analog_register_bus_host.sv]
// ----------------------------------------------------------------------------
// tb_analog_register_bus_host
// Drives word reads and writes into the bus host and checks every result in
// order. Results come from a predictor that tracks the command words, the
// analog control word with its PLL calibration, both configuration words and
// the full analog byte store. Covers a directed table, random traffic under
// three register settings, idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_analog_register_bus_host import abh_pkg::*; ();

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RAND_PER_PHASE = 258;
    localparam int HOLD_CYCLES    = 300;
    localparam int N_DIRECTED     = 27;

    localparam logic [3:0] W_UNMAPPED_LO = W_CFG2 + 4'd1;
    localparam logic [3:0] W_UNMAPPED_HI = 4'hF;

    typedef struct packed {
        logic [31:0] data;
        logic        mapped;
    } t_bus_result;

    typedef struct packed {
        logic        act;
        logic [3:0]  widx;
        logic [31:0] wval;
        logic        powered;
        logic        fixed;
        logic [31:0] data;
        logic        mapped;
    } t_access_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        act = ACT_READ;
    logic [3:0]  widx = 4'd0;
    logic [31:0] wval = 32'd0;
    logic        powered = 1'b1;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] rd_word;
    logic        mapped_o;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // typed expectation travels with the payload of a directed row
    logic        drv_fixed = 1'b0;
    logic [31:0] drv_fixed_data = 32'd0;
    logic        drv_fixed_mapped = 1'b0;

    // register copies
    logic [31:0] cfg_ana_mask = 32'd3;
    logic [31:0] cfg_cfg_mask = 32'hFFFF_FFFF;
    logic [31:0] cfg_cfg2_mask = 32'hFFFF_FFFF;
    logic [7:0]  cfg_sar_id = 8'd0;
    logic        cfg_sar_en = 1'b0;

    // predicted block state
    logic [CMD_W-1:0] exp_cmd_word [HOSTS];
    logic [31:0]      exp_analog_word = 32'd0;
    logic [31:0]      exp_cfg_word = 32'd0;
    logic [31:0]      exp_cfg2_word = 32'd0;
    logic [7:0]       exp_byte_mem [0:(1 << STORE_AW) - 1];
    logic [1:0]       exp_calib_reads = 2'd0;
    logic             exp_calibrating = 1'b0;
    logic             exp_pll_done = 1'b0;

    t_bus_result pending_results [$];

    int tx_idle_pct = 20;
    int rx_idle_pct = 86;
    int hold_requests = 0;
    int errors = 0;
    int n_taken = 0;
    int n_results = 0;
    int n_sar_busy = 0;
    int n_done_reads = 0;

    t_access_row directed_rows [N_DIRECTED] = '{
        '{ACT_READ,  4'd0,          32'h0,         1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  4'd1,          32'h0,         1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_ANALOG,      32'h0,         1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_CFG,         32'h0,         1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_UNMAPPED_LO, 32'h0,         1'b1, 1'b1, 32'h0,         1'b0},
        '{ACT_WRITE, W_UNMAPPED_HI, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b0},
        '{ACT_WRITE, 4'd0,          32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  4'd0,          32'h0,         1'b1, 1'b1, 32'h03FF_FFFF, 1'b1},
        '{ACT_WRITE, 4'd1,          32'h02AB_FFFF, 1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  4'd1,          32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, 4'd0,          32'h0012_3456, 1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  4'd0,          32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, 4'd0,          32'h0377_105A, 1'b0, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  4'd0,          32'h0,         1'b0, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, 4'd0,          32'h0377_105A, 1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_WRITE, 4'd1,          32'h0200_105A, 1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  4'd1,          32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, W_ANALOG,      32'h1,         1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_ANALOG,      32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_READ,  W_ANALOG,      32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_READ,  W_ANALOG,      32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, W_ANALOG,      32'h3,         1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_ANALOG,      32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, W_ANALOG,      32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_ANALOG,      32'h0,         1'b1, 1'b0, 32'h0,         1'b0},
        '{ACT_WRITE, W_CFG,         32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0,         1'b1},
        '{ACT_READ,  W_CFG,         32'h0,         1'b1, 1'b0, 32'h0,         1'b0}
    };

    analog_register_bus_host DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (act),
        .i_word_index  (widx),
        .i_write_value (wval),
        .i_sar_powered (powered),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_rd_word     (rd_word),
        .o_mapped      (mapped_o),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        for (int h = 0; h < HOSTS; h++) exp_cmd_word[h] = '0;
        for (int a = 0; a < (1 << STORE_AW); a++) exp_byte_mem[a] = 8'h00;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %08h want %08h (result %0d)", what, got, want, n_results);
        errors++;
    endtask

    // advance the predicted state by one word access and return its result
    task automatic predict_access(input logic a, input logic [3:0] w, input logic [31:0] v,
                                  input logic pw, output t_bus_result res);
        logic [31:0]         cmd;
        logic [31:0]         now;
        logic [STORE_AW-1:0] idx;
        res.data = 32'd0;
        res.mapped = 1'b1;
        if (w < 4'(HOSTS)) begin
            if (a == ACT_WRITE) begin
                cmd = v & CMD_KNOWN;
                idx = {cmd[SLAVE_BITS-1:0], cmd[CMD_ADDR_LSB +: ADDR_BITS]};
                if (cmd[CMD_START] && cfg_sar_en && !pw &&
                    32'(cmd[SLAVE_BITS-1:0]) == 32'(cfg_sar_id)) begin
                    // SAR slave unpowered: park the command busy
                    cmd[CMD_BUSY] = 1'b1;
                    n_sar_busy++;
                end else if (cmd[CMD_START] && cmd[CMD_WRITE]) begin
                    exp_byte_mem[idx] = cmd[CMD_DATA_LSB +: 8];
                end else if (cmd[CMD_START]) begin
                    cmd[CMD_DATA_LSB +: 8] = exp_byte_mem[idx];
                end
                exp_cmd_word[w[HOST_W-1:0]] = cmd[CMD_W-1:0];
            end else begin
                res.data = 32'(exp_cmd_word[w[HOST_W-1:0]]);
            end
        end else if (w == W_ANALOG) begin
            if (a == ACT_WRITE) begin
                now = v & cfg_ana_mask;
                now[PLL_DONE] = 1'b0;
                if (now[STOP_LOW] && !now[STOP_HIGH] && !exp_analog_word[STOP_LOW]) begin
                    exp_calib_reads = 2'd0;
                    exp_calibrating = 1'b1;
                    exp_pll_done = 1'b0;
                end else if (now[STOP_HIGH]) begin
                    exp_calibrating = 1'b0;
                    exp_pll_done = 1'b0;
                end
                exp_analog_word = now;
            end else begin
                if (exp_calibrating) begin
                    if (exp_calib_reads < CNT_MAX) exp_calib_reads++;
                    if (exp_calib_reads >= DONE_READS) begin
                        exp_calibrating = 1'b0;
                        exp_pll_done = 1'b1;
                    end
                end
                res.data = exp_analog_word;
                res.data[PLL_DONE] = exp_pll_done;
                if (exp_pll_done) n_done_reads++;
            end
        end else if (w == W_CFG) begin
            if (a == ACT_WRITE) exp_cfg_word = v & cfg_cfg_mask;
            else res.data = exp_cfg_word;
        end else if (w == W_CFG2) begin
            if (a == ACT_WRITE) exp_cfg2_word = v & cfg_cfg2_mask;
            else res.data = exp_cfg2_word;
        end else begin
            res.mapped = 1'b0;
        end
    endtask

    // output side: check results, then record what each accepted transfer should give
    always @(posedge clk) begin
        t_bus_result want;
        t_bus_result calc;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    report("result with nothing pending", rd_word, 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (rd_word !== want.data) report("rd_word", rd_word, want.data);
                    if (mapped_o !== want.mapped)
                        report("mapped", 32'(mapped_o), 32'(want.mapped));
                end
            end
            if (in_valid && !in_stall) begin
                n_taken++;
                predict_access(act, widx, wval, powered, calc);
                if (drv_fixed) begin
                    calc.data = drv_fixed_data;
                    calc.mapped = drv_fixed_mapped;
                end
                pending_results.push_back(calc);
            end
        end
    end

    // receiver: random stall, or a long hold-off on request
    initial begin
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin
        for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 pending_results.size());
        $display("tb_analog_register_bus_host: errors");
        $finish;
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        logic [31:0] readback;
        readback = v;
        if (idx == CFG_SAR_ID) readback = {24'd0, v[7:0]};
        if (idx == CFG_SAR_EN) readback = {31'd0, v[0]};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // address still held: the new value shows on prdata
        @(posedge clk);
        if (prdata !== readback) report("prdata", prdata, readback);
        case (idx)
            CFG_ANA_MASK:  cfg_ana_mask = v;
            CFG_CFG_MASK:  cfg_cfg_mask = v;
            CFG_CFG2_MASK: cfg_cfg2_mask = v;
            CFG_SAR_ID:    cfg_sar_id = v[7:0];
            CFG_SAR_EN:    cfg_sar_en = v[0];
            default: ; // the analog reset value is only read back; the analog word resets to zero
        endcase
    endtask

    task automatic apply_settings(logic [31:0] ana_mask, logic [31:0] ana_rst,
                                  logic [31:0] cfg_mask, logic [31:0] cfg2_mask,
                                  logic [7:0] sar_id, logic sar_en);
        write_reg(CFG_ANA_MASK, ana_mask);
        write_reg(CFG_ANA_RST, ana_rst);
        write_reg(CFG_CFG_MASK, cfg_mask);
        write_reg(CFG_CFG2_MASK, cfg2_mask);
        write_reg(CFG_SAR_ID, 32'(sar_id));
        write_reg(CFG_SAR_EN, 32'(sar_en));
    endtask

    // drop valid and hold until every pending result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_access(t_access_row row);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        act <= row.act;
        widx <= row.widx;
        wval <= row.wval;
        powered <= row.powered;
        drv_fixed <= row.fixed;
        drv_fixed_data <= row.data;
        drv_fixed_mapped <= row.mapped;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic t_access_row random_access();
        t_access_row r;
        int pick;
        r = '0;
        pick = $urandom_range(99);
        r.act = 1'($urandom_range(1));
        r.wval = $urandom;
        r.powered = ($urandom_range(3) != 0);
        if (pick < 8) begin
            r.widx = 4'($urandom_range(15));
        end else if (pick < 55) begin
            r.widx = 4'($urandom_range(HOSTS - 1));
            if (r.act == ACT_WRITE) begin
                // concentrate on a few slaves and addresses so reads hit written bytes
                case ($urandom_range(7))
                    0, 1:    r.wval[7:0] = cfg_sar_id;
                    2:       r.wval[7:0] = 8'($urandom);
                    default: r.wval[7:0] = 8'($urandom_range(3));
                endcase
                if ($urandom_range(3) != 0) r.wval[15:8] = 8'($urandom_range(7));
                r.wval[CMD_START] = ($urandom_range(4) != 0);
            end
        end else if (pick < 82) begin
            r.widx = W_ANALOG;
            if (r.act == ACT_WRITE) begin
                case ($urandom_range(5))
                    0:       r.wval = 32'h1;
                    1:       r.wval = 32'h3;
                    2:       r.wval = 32'h0;
                    3:       r.wval = 32'h2;
                    default: ;
                endcase
            end
        end else begin
            r.widx = (pick < 91) ? W_CFG : W_CFG2;
        end
        return r;
    endfunction

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_settings(32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 8'h5A, 1'b1);
        for (int i = 0; i < N_DIRECTED; i++) send_access(directed_rows[i]);
        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 86;
                end
                1: begin
                    apply_settings(32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 8'hFF, 1'b0);
                    tx_idle_pct = 86;
                    rx_idle_pct = 20;
                end
                default: begin
                    apply_settings(32'h3, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1);
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                if (i == RAND_PER_PHASE / 3) drain_results();
                // output held off while the sender keeps offering
                if (phase == 2 && i == RAND_PER_PHASE / 2) hold_requests++;
                send_access(random_access());
            end
        end
        drain_results();
        $display("covered %0d transfers in, %0d results checked, 3 register settings",
                 n_taken, n_results);
        $display("SAR-blocked commands %0d, reads with PLL done %0d", n_sar_busy, n_done_reads);
        if (errors == 0) begin
            $display("tb_analog_register_bus_host: clean");
        end else begin
            $display("tb_analog_register_bus_host: errors");
        end
        $finish;
    end

endmodule
